// ===== design/lmsd_pkg.sv =====
// Shared types and constants for the LED matrix scan dimmer.
`default_nettype none

package lmsd_pkg;

    // Field widths of the item and result beats
    localparam int MODE_W = 3;
    localparam int COL_W  = 4;
    localparam int ROW_W  = 5;
    localparam int SEL_W  = 12;
    localparam int ROWS_W = 32;
    localparam int BRIGHT_W = 8;

    // One-hot decode width covering every column index the column field can hold
    localparam int ONEHOT_W = 16;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_BRIGHTNESS = 1'b0;

    // Parameter defaults
    localparam int COLUMNS_DEFAULT    = 12;
    localparam int ROW_BITS_DEFAULT   = 32;
    localparam int TIMER_BITS_DEFAULT = 8;

    localparam logic [BRIGHT_W-1:0] BRIGHT_CLAMP     = 8'd200;
    localparam logic [BRIGHT_W-1:0] DARK_COMPARE     = 8'd255;
    localparam logic [BRIGHT_W-1:0] RESET_BRIGHTNESS = 8'd128;
    localparam logic [BRIGHT_W-1:0] RESET_COMPARE    = 8'd127;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET       = 3'd0,
        MODE_CLEAR     = 3'd1,
        MODE_TOGGLE    = 3'd2,
        MODE_CLEAR_ALL = 3'd3,
        MODE_TICK      = 3'd4
    } mode_t;

    // Decoded operation of the item in flight
    typedef struct packed {
        logic do_set;
        logic do_clear;
        logic do_toggle;
        logic do_clear_all;
        logic do_tick;
    } item_op_t;

    // Scan status after the item in flight
    typedef struct packed {
        logic lit;
        logic frame;
    } scan_status_t;

endpackage

`default_nettype wire

// ===== design/led_matrix_scan_dimmer.sv =====
// LED matrix scanner with PWM dimming: top level with input and result registers.
//
// Use:
//   Input beats (in_valid/in_stall) carry mode, column and row. Modes set, clear
//   and toggle one bitmap bit, clear-all empties the bitmap, and tick advances
//   the scan timer. Every input beat yields exactly one result beat
//   (out_valid/out_stall) with output_enable, frame_valid, column_select,
//   row_bits and bit_state.
//   Each beat passes the input register, then the result register, before
//   out_valid shows it. Throughput: one beat per cycle while the receiver
//   does not stall, set by the read-modify-write of the bitmap row and the
//   timer compare.
//   When the receiver stalls, the result register holds its beat and one more
//   beat waits in the input register; in_stall rises only when both are full.
//   The brightness register sits at byte address 0 of the APB-style port;
//   write it only while no beat is in flight.
//   Reset clears the bitmap, the timer and the active column, loads the
//   compare value 127 and the brightness 128, and blanks the output.
`default_nettype none

module led_matrix_scan_dimmer #(
    parameter int COLUMNS    = lmsd_pkg::COLUMNS_DEFAULT,
    parameter int ROW_BITS   = lmsd_pkg::ROW_BITS_DEFAULT,
    parameter int TIMER_BITS = lmsd_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [lmsd_pkg::MODE_W-1:0]       mode,
    input  wire logic [lmsd_pkg::COL_W-1:0]        column,
    input  wire logic [lmsd_pkg::ROW_W-1:0]        row,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   output_enable,
    output logic                                   frame_valid,
    output logic      [lmsd_pkg::SEL_W-1:0]        column_select,
    output logic      [lmsd_pkg::ROWS_W-1:0]       row_bits,
    output logic                                   bit_state,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lmsd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [lmsd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [lmsd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    localparam int CIW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // Input register
    logic                          in_valid_reg;
    logic [lmsd_pkg::MODE_W-1:0]   mode_reg;
    logic [lmsd_pkg::COL_W-1:0]    column_reg;
    logic [lmsd_pkg::ROW_W-1:0]    row_reg;

    // Result register
    logic                          out_valid_reg;
    logic                          oe_reg;
    logic                          frame_reg;
    logic [lmsd_pkg::SEL_W-1:0]    sel_reg;
    logic [lmsd_pkg::ROWS_W-1:0]   rows_reg;
    logic                          bit_reg;

    logic                          advance;
    logic                          in_accept;
    lmsd_pkg::item_op_t            op;
    lmsd_pkg::scan_status_t        status;
    logic [CIW-1:0]                scan_column;
    logic [ROW_BITS-1:0]           scan_rows;
    logic                          bit_value;
    logic [lmsd_pkg::BRIGHT_W-1:0] brightness;
    logic [lmsd_pkg::ONEHOT_W-1:0] onehot;

    // Advance the held beat when the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // Decode the held mode; unused codes do nothing
    always_comb
    begin
        op = '0;
        if (advance)
        begin
            case (lmsd_pkg::mode_t'(mode_reg))
                lmsd_pkg::MODE_SET:       op.do_set       = 1'b1;
                lmsd_pkg::MODE_CLEAR:     op.do_clear     = 1'b1;
                lmsd_pkg::MODE_TOGGLE:    op.do_toggle    = 1'b1;
                lmsd_pkg::MODE_CLEAR_ALL: op.do_clear_all = 1'b1;
                lmsd_pkg::MODE_TICK:      op.do_tick      = 1'b1;
                default:                  op              = '0;
            endcase
        end
    end

    lmsd_apb u_apb (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .brightness (brightness)
    );

    lmsd_bitmap #(
        .COLUMNS  (COLUMNS),
        .ROW_BITS (ROW_BITS),
        .CIW      (CIW)
    ) u_bitmap (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .column      (column_reg),
        .row         (row_reg),
        .scan_column (scan_column),
        .bit_state   (bit_value),
        .scan_rows   (scan_rows)
    );

    lmsd_scan #(
        .COLUMNS    (COLUMNS),
        .TIMER_BITS (TIMER_BITS),
        .CIW        (CIW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (op.do_tick),
        .brightness  (brightness),
        .status      (status),
        .scan_column (scan_column)
    );

    // Column select is the one-hot of the frame column, cut to the port width
    assign onehot = lmsd_pkg::ONEHOT_W'(1) << scan_column;

    // Control: valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold the input beat and load the result beat
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg   <= mode;
            column_reg <= column;
            row_reg    <= row;
        end
        if (advance)
        begin
            oe_reg    <= status.lit;
            frame_reg <= status.frame;
            sel_reg   <= status.frame ? onehot[lmsd_pkg::SEL_W-1:0] : '0;
            rows_reg  <= status.frame ? lmsd_pkg::ROWS_W'(scan_rows) : '0;
            bit_reg   <= bit_value;
        end
    end

    assign out_valid     = out_valid_reg;
    assign output_enable = oe_reg;
    assign frame_valid   = frame_reg;
    assign column_select = sel_reg;
    assign row_bits      = rows_reg;
    assign bit_state     = bit_reg;

`ifndef SYNTHESIS
    a_frame_blanks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_valid |-> !output_enable)
        else $error("frame beat with the output lit");

    a_no_frame_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_valid |-> (column_select == '0) && (row_bits == '0))
        else $error("column or row bits outside a frame beat");

    a_frame_not_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_valid |-> !bit_state && $onehot0(column_select))
        else $error("frame beat with a bit state or several columns");

    a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with no beat held");
`endif

endmodule

`default_nettype wire

// ===== design/lmsd_apb.sv =====
// Brightness register behind the APB-style configuration port.
`default_nettype none

module lmsd_apb (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lmsd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [lmsd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [lmsd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output logic      [lmsd_pkg::BRIGHT_W-1:0]     brightness
);

    logic [lmsd_pkg::BRIGHT_W-1:0] brightness_reg;
    logic [lmsd_pkg::BRIGHT_W-1:0] brightness_next;
    logic                          hit;

    assign hit = (paddr[lmsd_pkg::APB_ADDR_W-1] == lmsd_pkg::REG_BRIGHTNESS);

    always_comb
    begin
        brightness_next = brightness_reg;
        if (psel && penable && pwrite && hit)
        begin
            brightness_next = pwdata[lmsd_pkg::BRIGHT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= lmsd_pkg::RESET_BRIGHTNESS;
        end
        else
        begin
            brightness_reg <= brightness_next;
        end
    end

    assign pready     = 1'b1;
    assign prdata     = hit ? lmsd_pkg::APB_DATA_W'(brightness_reg) : '0;
    assign brightness = brightness_reg;

endmodule

`default_nettype wire

// ===== design/lmsd_bitmap.sv =====
// Bitmap store: single-bit updates, clear-all and the frame row read.
`default_nettype none

module lmsd_bitmap #(
    parameter int COLUMNS  = lmsd_pkg::COLUMNS_DEFAULT,
    parameter int ROW_BITS = lmsd_pkg::ROW_BITS_DEFAULT,
    parameter int CIW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lmsd_pkg::item_op_t            op,
    input  wire logic [lmsd_pkg::COL_W-1:0]    column,
    input  wire logic [lmsd_pkg::ROW_W-1:0]    row,
    input  wire logic [CIW-1:0]                scan_column,
    output logic                               bit_state,
    output logic      [ROW_BITS-1:0]           scan_rows
);

    localparam int RIW = (ROW_BITS > 1) ? $clog2(ROW_BITS) : 1;

    logic [ROW_BITS-1:0] bitmap_reg [COLUMNS];
    logic [ROW_BITS-1:0] word_next;
    logic [ROW_BITS-1:0] word;
    logic [ROW_BITS-1:0] bit_mask;
    logic [CIW-1:0]      rd_idx;
    logic                addr_ok;
    logic                bit_op;
    logic                old_bit;

    assign addr_ok = ((lmsd_pkg::COL_W + 1)'(column) < (lmsd_pkg::COL_W + 1)'(COLUMNS))
                  && (((lmsd_pkg::ROW_W + 1)'(row) + (lmsd_pkg::ROW_W + 1)'(1))
                      < (lmsd_pkg::ROW_W + 1)'(ROW_BITS));
    assign bit_op  = addr_ok && (op.do_set || op.do_clear || op.do_toggle);

    // One read port: the scan column on a tick, the addressed column otherwise
    always_comb
    begin
        if (op.do_tick)
        begin
            rd_idx = scan_column;
        end
        else if (addr_ok)
        begin
            rd_idx = column[CIW-1:0];
        end
        else
        begin
            rd_idx = '0;
        end
    end

    assign word     = bitmap_reg[rd_idx];
    assign bit_mask = ROW_BITS'(1) << row[RIW-1:0];
    assign old_bit  = |(word & bit_mask);

    always_comb
    begin
        word_next = word;
        if (op.do_set)
        begin
            word_next = word | bit_mask;
        end
        else if (op.do_clear)
        begin
            word_next = word & ~bit_mask;
        end
        else if (op.do_toggle)
        begin
            word_next = word ^ bit_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COLUMNS; i++)
            begin
                bitmap_reg[i] <= '0;
            end
        end
        else if (op.do_clear_all)
        begin
            for (int i = 0; i < COLUMNS; i++)
            begin
                bitmap_reg[i] <= '0;
            end
        end
        else if (bit_op)
        begin
            bitmap_reg[rd_idx] <= word_next;
        end
    end

    assign bit_state = bit_op && (op.do_set || (op.do_toggle && !old_bit));
    assign scan_rows = word;

endmodule

`default_nettype wire

// ===== design/lmsd_scan.sv =====
// Scan timer, blanking compare and active column sequencing.
`default_nettype none

module lmsd_scan #(
    parameter int COLUMNS    = lmsd_pkg::COLUMNS_DEFAULT,
    parameter int TIMER_BITS = lmsd_pkg::TIMER_BITS_DEFAULT,
    parameter int CIW        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             tick,
    input  wire logic [lmsd_pkg::BRIGHT_W-1:0]    brightness,
    output lmsd_pkg::scan_status_t                status,
    output logic      [CIW-1:0]                   scan_column
);

    localparam int CW = (TIMER_BITS > lmsd_pkg::BRIGHT_W) ? TIMER_BITS : lmsd_pkg::BRIGHT_W;

    logic [TIMER_BITS-1:0]         timer_reg, timer_next;
    logic [lmsd_pkg::BRIGHT_W-1:0] compare_reg, compare_next;
    logic                          lit_reg, lit_next;
    logic [CIW-1:0]                column_reg, column_next;
    logic [lmsd_pkg::BRIGHT_W-1:0] clamped;
    logic                          frame;

    assign clamped = (brightness > lmsd_pkg::BRIGHT_CLAMP) ? lmsd_pkg::BRIGHT_CLAMP : brightness;

    always_comb
    begin
        timer_next   = timer_reg;
        compare_next = compare_reg;
        lit_next     = lit_reg;
        column_next  = column_reg;
        frame        = 1'b0;
        if (tick)
        begin
            timer_next = timer_reg + TIMER_BITS'(1);
            if (timer_next == '0)
            begin
                // Wrap: blank, latch the compare and step the column
                compare_next = ~clamped;
                lit_next     = 1'b0;
                frame        = 1'b1;
                column_next  = (column_reg == CIW'(COLUMNS - 1)) ? '0
                             : column_reg + CIW'(1);
            end
            else if ((CW'(timer_next) == CW'(compare_reg))
                     && (compare_reg != lmsd_pkg::DARK_COMPARE))
            begin
                lit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg   <= '0;
            compare_reg <= lmsd_pkg::RESET_COMPARE;
            lit_reg     <= 1'b0;
            column_reg  <= '0;
        end
        else
        begin
            timer_reg   <= timer_next;
            compare_reg <= compare_next;
            lit_reg     <= lit_next;
            column_reg  <= column_next;
        end
    end

    assign status.lit   = lit_next;
    assign status.frame = frame;
    assign scan_column  = column_reg;

`ifndef SYNTHESIS
    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CW + 1)'(column_reg) < (CW + 1)'(COLUMNS))
        else $error("active column beyond the last column");

    a_compare_floor: assert property (@(posedge clk) disable iff (!rst_n)
        compare_reg >= ~lmsd_pkg::BRIGHT_CLAMP)
        else $error("compare value below the clamped floor");

    a_dark_stays_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (compare_reg == lmsd_pkg::DARK_COMPARE) && !lit_reg && !$rose(compare_reg == lmsd_pkg::DARK_COMPARE) |=> !lit_reg || (compare_reg != $past(compare_reg)))
        else $error("output lit with a dark compare value");
`endif

endmodule

`default_nettype wire

// ===== tb/led_matrix_scan_dimmer_tb.sv =====
// Self-checking testbench for the LED matrix scan dimmer: bitmap edits, scan ticks and dimming.
module led_matrix_scan_dimmer_tb;

    import lmsd_pkg::*;

    localparam int NUM_COLS    = COLUMNS_DEFAULT;
    localparam int NUM_ROWS    = ROW_BITS_DEFAULT;
    localparam int TIMER_W     = TIMER_BITS_DEFAULT;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 300;
    // Cycles to let pass once every expected beat is home; covers the
    // two-stage pipe with margin.
    localparam int SETTLE      = 6;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [APB_ADDR_W-1:0] BRIGHT_ADDR = APB_ADDR_W'(4 * REG_BRIGHTNESS);

    // One result beat, field for field as it leaves the block
    typedef struct packed {
        logic                output_enable;
        logic                frame_valid;
        logic [SEL_W-1:0]    column_select;
        logic [ROWS_W-1:0]   row_bits;
        logic                bit_state;
    } scan_result_t;

    // Mirror of the block's bitmap, scan timer and dimming state. Every
    // accepted item beat yields exactly one expected result beat.
    class matrix_scoreboard;
        logic [ROWS_W-1:0]   bitmap [NUM_COLS];
        logic [TIMER_W-1:0]  timer;
        int                  col_ptr;
        logic [BRIGHT_W-1:0] compare;
        logic                lit;
        logic [BRIGHT_W-1:0] brightness;
        scan_result_t        pending_results [$];
        int                  fails;

        function new();
            foreach (bitmap[i])
                bitmap[i] = '0;
            timer      = '0;
            col_ptr    = 0;
            compare    = RESET_COMPARE;
            lit        = 1'b0;
            brightness = RESET_BRIGHTNESS;
            fails      = 0;
        endfunction

        function void set_brightness(logic [BRIGHT_W-1:0] level);
            brightness = level;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void accept_item(logic [MODE_W-1:0] m, logic [COL_W-1:0] c,
                                  logic [ROW_W-1:0] r);
            scan_result_t        res;
            logic [BRIGHT_W-1:0] level;
            res = '0;
            case (m)
                MODE_SET, MODE_CLEAR, MODE_TOGGLE:
                    // Out-of-range column or the top row bit: leave the bitmap alone
                    if (c < NUM_COLS && r < NUM_ROWS - 1)
                    begin
                        if (m == MODE_SET)
                            bitmap[c][r] = 1'b1;
                        else if (m == MODE_CLEAR)
                            bitmap[c][r] = 1'b0;
                        else
                            bitmap[c][r] = ~bitmap[c][r];
                        res.bit_state = bitmap[c][r];
                    end
                MODE_CLEAR_ALL:
                    foreach (bitmap[i])
                        bitmap[i] = '0;
                MODE_TICK:
                begin
                    timer = timer + 1'b1;
                    if (timer == '0)
                    begin
                        // Wrap: blank first, latch the inverted clamped level,
                        // emit the current column and advance
                        level = (brightness > BRIGHT_CLAMP) ? BRIGHT_CLAMP : brightness;
                        compare               = ~level;
                        lit                   = 1'b0;
                        res.frame_valid       = 1'b1;
                        res.column_select     = SEL_W'(1) << col_ptr;
                        res.row_bits          = bitmap[col_ptr];
                        col_ptr               = (col_ptr + 1) % NUM_COLS;
                    end
                    else if (timer == compare && compare != DARK_COMPARE)
                        lit = 1'b1;
                end
                default: ;
            endcase
            res.output_enable = lit;
            pending_results.push_back(res);
        endfunction

        function void check_result(scan_result_t got);
            scan_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result beat arrived with nothing expected");
                fails++;
                return;
            end
            want = pending_results.pop_front();
            if (got.output_enable !== want.output_enable)
            begin
                $error("output_enable: expected %0d, got %0d",
                       want.output_enable, got.output_enable);
                fails++;
            end
            if (got.frame_valid !== want.frame_valid)
            begin
                $error("frame_valid: expected %0d, got %0d",
                       want.frame_valid, got.frame_valid);
                fails++;
            end
            if (got.column_select !== want.column_select)
            begin
                $error("column_select: expected %03h, got %03h",
                       want.column_select, got.column_select);
                fails++;
            end
            if (got.row_bits !== want.row_bits)
            begin
                $error("row_bits: expected %08h, got %08h", want.row_bits, got.row_bits);
                fails++;
            end
            if (got.bit_state !== want.bit_state)
            begin
                $error("bit_state: expected %0d, got %0d", want.bit_state, got.bit_state);
                fails++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [MODE_W-1:0]     mode     = '0;
    logic [COL_W-1:0]      column   = '0;
    logic [ROW_W-1:0]      row      = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  output_enable;
    logic                  frame_valid;
    logic [SEL_W-1:0]      column_select;
    logic [ROWS_W-1:0]     row_bits;
    logic                  bit_state;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    matrix_scoreboard board = new();

    // Stretches of back-to-back beats on either side, flipped at random
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    int unsigned cycle_count;

    led_matrix_scan_dimmer dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one item beat after a random gap and hold it until taken. Valid is
    // only dropped when a gap follows, so a back-to-back beat never sees it
    // lowered and raised in one step.
    task automatic push_item(input logic [MODE_W-1:0] m, input logic [COL_W-1:0] c,
                             input logic [ROW_W-1:0] r);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        column   <= c;
        row      <= r;
        do
            @(posedge clk);
        while (in_stall);
        board.accept_item(m, c, r);
    endtask

    // Mostly ticks, so the timer wraps about once per phase; edits aim mostly
    // at valid addresses, with a share of out-of-range ones and spare modes.
    task automatic push_random_item();
        int                pick;
        logic [MODE_W-1:0] m;
        logic [COL_W-1:0]  c;
        logic [ROW_W-1:0]  r;
        pick = $urandom_range(0, 99);
        if (pick < 88)
            m = MODE_TICK;
        else if (pick < 93)
            m = MODE_SET;
        else if (pick < 95)
            m = MODE_CLEAR;
        else if (pick < 97)
            m = MODE_TOGGLE;
        else if (pick < 98)
            m = MODE_CLEAR_ALL;
        else
            m = MODE_W'($urandom_range(int'(MODE_TICK) + 1, 2 ** MODE_W - 1));
        if ($urandom_range(0, 9) == 0)
            c = COL_W'($urandom_range(NUM_COLS, 2 ** COL_W - 1));
        else
            c = COL_W'($urandom_range(0, NUM_COLS - 1));
        if ($urandom_range(0, 9) == 0)
            r = ROW_W'(NUM_ROWS - 1);
        else
            r = ROW_W'($urandom_range(0, NUM_ROWS - 2));
        push_item(m, c, r);
    endtask

    // Drop valid and hold off until every expected beat is home, then let the
    // pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write the brightness register (setup then access), then read it back.
    task automatic write_brightness(input logic [BRIGHT_W-1:0] level);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= BRIGHT_ADDR;
        pwdata  <= APB_DATA_W'(level);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_brightness(level);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== APB_DATA_W'(level))
        begin
            $error("brightness_request: expected %0d, got %0d", level, prdata);
            board.fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: stall a random number of cycles, then take the next beat
    // and check it against the oldest expectation.
    initial
    begin
        int           hold;
        scan_result_t got;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
            hold = rx_calm ? 0 : $urandom_range(0, 8);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            got.output_enable = output_enable;
            got.frame_valid   = frame_valid;
            got.column_select = column_select;
            got.row_bits      = row_bits;
            got.bit_state     = bit_state;
            board.check_result(got);
        end
    end

    // Watchdog: end the run if it never completes
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int                  phase;
        logic [BRIGHT_W-1:0] levels [PHASES-1];
        levels = '{8'd0, 8'hFF, BRIGHT_CLAMP, 8'd0};
        levels[PHASES-2] = BRIGHT_W'($urandom_range(1, 254));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corner addresses, each edit kind, out-of-range edits,
        // spare modes, clear-all and a few ticks
        push_item(MODE_SET, 4'd0, 5'd0);
        push_item(MODE_SET, 4'd11, 5'd30);
        push_item(MODE_SET, 4'd5, 5'd17);
        push_item(MODE_TOGGLE, 4'd11, 5'd30);
        push_item(MODE_TOGGLE, 4'd3, 5'd3);
        push_item(MODE_CLEAR, 4'd5, 5'd17);
        push_item(MODE_CLEAR, 4'd0, 5'd0);
        push_item(MODE_SET, 4'd12, 5'd0);
        push_item(MODE_SET, 4'd15, 5'd31);
        push_item(MODE_TOGGLE, 4'd0, 5'd31);
        push_item(MODE_CLEAR, 4'd15, 5'd10);
        push_item(MODE_TOGGLE, 4'd12, 5'd30);
        for (int m = int'(MODE_TICK) + 1; m < 2 ** MODE_W; m++)
            push_item(MODE_W'(m), 4'd15, 5'd31);
        push_item(MODE_SET, 4'd11, 5'd30);
        push_item(MODE_SET, 4'd0, 5'd0);
        push_item(MODE_SET, 4'd10, 5'd21);
        push_item(MODE_CLEAR_ALL, 4'd7, 5'd14);
        push_item(MODE_TOGGLE, 4'd6, 5'd9);
        repeat (3) push_item(MODE_TICK, 4'd0, 5'd0);

        // Random phases: the first at the reset brightness, then off, over
        // the clamp, at the clamp and a random level. Drain before each
        // write so the register only changes while the block is idle.
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                write_brightness(levels[phase-1]);
            end
            repeat (PHASE_ITEMS) push_random_item();
        end

        drain();
        if (board.fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
